[rtl/kld_pkg.sv]
`default_nettype none

package kld_pkg;

    localparam int PROB_W            = 17;
    localparam int PROB_FRAC_BITS_DEF = 16;
    localparam int LOG_STEPS         = 16;
    localparam int STEP_CNT_W        = $clog2(2 * LOG_STEPS);
    localparam int EXP_W             = 5;
    localparam int MANT_W            = 31;
    localparam int LOG_INT_W         = 6;
    localparam int LOG_W             = LOG_INT_W + LOG_STEPS;
    localparam int LN_W              = LOG_W;
    localparam int SUM_W             = 48;
    localparam int OUT_W             = 32;
    localparam int S_DATA_W          = 40;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;

    typedef struct packed {
        logic load;
        logic square;
        logic sel_q;
        logic ln;
        logic term;
        logic acc;
        logic emit;
    } kld_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } kld_sts_t;

endpackage

`default_nettype wire

[rtl/kld_ctrl.sv]
`default_nettype none

module kld_ctrl
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire kld_pkg::kld_sts_t sts,
    output kld_pkg::kld_cmd_t     cmd
);

    typedef enum logic [5:0]
    {
        S_IDLE   = 6'b000001,
        S_SQUARE = 6'b000010,
        S_LN     = 6'b000100,
        S_TERM   = 6'b001000,
        S_ACC    = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    localparam logic [kld_pkg::STEP_CNT_W-1:0] STEP_LAST =
        kld_pkg::STEP_CNT_W'(2 * kld_pkg::LOG_STEPS - 1);

    state_t                          state_reg;
    state_t                          state_next;
    logic [kld_pkg::STEP_CNT_W-1:0]  step_cnt_reg;
    logic [kld_pkg::STEP_CNT_W-1:0]  step_cnt_next;

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        cmd           = '0;
        s_tready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load      = 1'b1;
                    step_cnt_next = '0;
                    state_next    = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square    = 1'b1;
                cmd.sel_q     = step_cnt_reg[0];
                step_cnt_next = step_cnt_reg + 1'b1;
                if (step_cnt_reg == STEP_LAST)
                begin
                    step_cnt_next = '0;
                    state_next    = S_LN;
                end
            end
            S_LN:
            begin
                cmd.ln     = 1'b1;
                state_next = S_TERM;
            end
            S_TERM:
            begin
                cmd.term   = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.last ? S_DONE : S_IDLE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                step_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted while output register busy");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (step_cnt_reg == '0))
        else $error("step counter not cleared in idle");

    a_square_to_ln: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.square && step_cnt_reg == STEP_LAST) |=> cmd.ln)
        else $error("squaring run did not end in ln step");

    a_nonlast_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.acc && !sts.last) |=> s_tready)
        else $error("non-last transaction did not return to idle");
`endif

endmodule

`default_nettype wire

[rtl/kld_datapath.sv]
`default_nettype none

module kld_datapath
#(
    parameter int PROB_FRAC_BITS = kld_pkg::PROB_FRAC_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire kld_pkg::kld_cmd_t              cmd,
    output kld_pkg::kld_sts_t                   sts,
    input  wire logic [kld_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                           s_tlast,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [kld_pkg::OUT_W-1:0]           m_tdata,
    output logic                                m_tuser
);

    localparam int PW     = kld_pkg::PROB_W;
    localparam int MW     = kld_pkg::MANT_W;
    localparam int EW     = kld_pkg::EXP_W;
    localparam int FW     = kld_pkg::LOG_STEPS;
    localparam int IW     = kld_pkg::LOG_INT_W;
    localparam int LW     = kld_pkg::LOG_W;
    localparam int NW     = kld_pkg::LN_W;
    localparam int SW     = kld_pkg::SUM_W;
    localparam int OW     = kld_pkg::OUT_W;
    localparam int TPW    = PW + NW;
    localparam int TMAG_W = TPW - PROB_FRAC_BITS;
    localparam int LNP_W  = NW + 32;

    function automatic logic [EW-1:0] msb_index(input logic [PW-1:0] x);
        logic [EW-1:0] e;
        e = '0;
        for (int b = 0; b < PW; b++)
        begin
            if (x[b])
            begin
                e = EW'(b);
            end
        end
        return e;
    endfunction

    function automatic logic [MW-1:0] normalize(input logic [PW-1:0] x,
                                                input logic [EW-1:0] e);
        logic [MW+PW-1:0] wide;
        wide = {{MW{1'b0}}, x} << (EW'(MW - 1) - e);
        return wide[MW-1:0];
    endfunction

    logic [PW-1:0]     in_p;
    logic [PW-1:0]     in_q;
    logic [EW-1:0]     in_ep;
    logic [EW-1:0]     in_eq;

    logic [PW-1:0]     p_reg;
    logic              last_reg;
    logic              nz_reg;
    logic [EW-1:0]     ep_reg;
    logic [EW-1:0]     eq_reg;
    logic [MW-1:0]     mp_reg;
    logic [MW-1:0]     mq_reg;
    logic [FW-1:0]     fp_reg;
    logic [FW-1:0]     fq_reg;
    logic [NW-1:0]     ln_reg;
    logic              neg_reg;
    logic [TMAG_W-1:0] tmag_reg;
    logic [SW-1:0]     sum_reg;
    logic [SW-1:0]     sum_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic [OW-1:0]     out_data_reg;
    logic              out_sat_reg;

    logic [MW-1:0]     sq_op;
    logic [2*MW-1:0]   sq_prod;
    logic [MW:0]       sq_top;
    logic [MW-1:0]     sq_mant;
    logic              sq_bit;

    logic signed [IW-1:0] ip_p;
    logic signed [IW-1:0] ip_q;
    logic signed [LW-1:0] log_p;
    logic signed [LW-1:0] log_q;
    logic signed [LW:0]   log_d;
    logic [NW-1:0]        d_mag;
    logic [LNP_W-1:0]     ln_prod;
    logic [TPW-1:0]       t_prod;
    logic [TPW-1:0]       t_shift;
    logic signed [SW:0]   term_ext;
    logic signed [SW:0]   sum_sum;
    logic                 fits_out;
    logic [OW-1:0]        out_clip;

    assign in_p  = s_tdata[PW-1:0];
    assign in_q  = s_tdata[2*PW-1:PW];
    assign in_ep = msb_index(in_p);
    assign in_eq = msb_index(in_q);

    assign sq_op   = cmd.sel_q ? mq_reg : mp_reg;
    assign sq_prod = (2*MW)'(sq_op) * (2*MW)'(sq_op);
    assign sq_top  = sq_prod[2*MW-1:MW-1];
    assign sq_bit  = sq_top[MW];
    assign sq_mant = sq_bit ? sq_top[MW:1] : sq_top[MW-1:0];

    assign ip_p    = IW'({1'b0, ep_reg}) - IW'(PROB_FRAC_BITS);
    assign ip_q    = IW'({1'b0, eq_reg}) - IW'(PROB_FRAC_BITS);
    assign log_p   = {ip_p, fp_reg};
    assign log_q   = {ip_q, fq_reg};
    assign log_d   = (LW+1)'(log_p) - (LW+1)'(log_q);
    assign d_mag   = log_d[LW] ? NW'(-log_d) : log_d[NW-1:0];
    assign ln_prod = LNP_W'(d_mag) * LNP_W'(kld_pkg::LN2_Q32);

    assign t_prod  = TPW'(p_reg) * TPW'(ln_reg);
    assign t_shift = t_prod >> PROB_FRAC_BITS;

    assign term_ext = neg_reg ? -(SW+1)'(tmag_reg) : (SW+1)'(tmag_reg);
    assign sum_sum  = (SW+1)'(signed'(sum_reg)) + term_ext;

    always_comb
    begin
        sum_next = sum_reg;
        ovf_next = ovf_reg;
        if (cmd.emit)
        begin
            sum_next = '0;
            ovf_next = 1'b0;
        end
        else if (cmd.acc && nz_reg)
        begin
            if (sum_sum[SW] != sum_sum[SW-1])
            begin
                sum_next = sum_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
                ovf_next = 1'b1;
            end
            else
            begin
                sum_next = sum_sum[SW-1:0];
            end
        end
    end

    assign fits_out = (&sum_reg[SW-1:OW-1]) || !(|sum_reg[SW-1:OW-1]);
    assign out_clip = fits_out ? sum_reg[OW-1:0]
                    : (sum_reg[SW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg    <= in_p;
            last_reg <= s_tlast;
            nz_reg   <= (in_p != '0) && (in_q != '0);
            ep_reg   <= in_ep;
            eq_reg   <= in_eq;
            mp_reg   <= normalize(in_p, in_ep);
            mq_reg   <= normalize(in_q, in_eq);
            fp_reg   <= '0;
            fq_reg   <= '0;
        end
        else if (cmd.square)
        begin
            if (cmd.sel_q)
            begin
                mq_reg <= sq_mant;
                fq_reg <= {fq_reg[FW-2:0], sq_bit};
            end
            else
            begin
                mp_reg <= sq_mant;
                fp_reg <= {fp_reg[FW-2:0], sq_bit};
            end
        end
        if (cmd.ln)
        begin
            ln_reg  <= ln_prod[LNP_W-1:32];
            neg_reg <= log_d[LW];
        end
        if (cmd.term)
        begin
            tmag_reg <= t_shift[TMAG_W-1:0];
        end
        if (cmd.emit)
        begin
            out_data_reg <= out_clip;
            out_sat_reg  <= ovf_reg || !fits_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            ovf_reg <= ovf_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.last     = last_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_sat_reg;

`ifndef SYNTHESIS
    a_emit_clears_sum: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (sum_reg == '0) && !ovf_reg && m_tvalid)
        else $error("sum not cleared or result not shown after emit");

    a_sum_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (!cmd.acc && !cmd.emit) |=> $stable(sum_reg))
        else $error("running sum changed outside accumulate step");

    a_mant_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.square && nz_reg) |-> sq_op[MW-1])
        else $error("mantissa lost normalization during squaring");
`endif

endmodule

`default_nettype wire

[rtl/kl_divergence_accumulator.sv]
`default_nettype none

// channel  dir  handshake          payload
// s_axis   in   s_tvalid/s_tready  s_tdata: class_prob, global_prob; s_tlast: last_slot
// m_axis   out  m_tvalid/m_tready  m_tdata: influence; m_tuser: saturated
//
// the next transaction is accepted only after the previous one is through and the block is back in idle
// each runs the 32 squaring steps of the two log2 evaluations on one multiplier,
// plus the accept, ln, term and accumulate steps, and a last one also the emit step
// reset clears the running sum, overflow flag, controller and output valid
// a result waits in the output register while the next transaction is accepted
// the block stalls before showing a new result only while the previous one is still held

module kl_divergence_accumulator
#(
    parameter int PROB_FRAC_BITS = kld_pkg::PROB_FRAC_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [kld_pkg::S_DATA_W-1:0] s_tdata,   // class_prob, global_prob, zero pad
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [kld_pkg::OUT_W-1:0]         m_tdata,   // influence
    output logic                              m_tuser    // saturated
);

    kld_pkg::kld_cmd_t cmd;
    kld_pkg::kld_sts_t sts;

    kld_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kld_datapath
    #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

[tb/kl_divergence_accumulator_tb.sv]
`timescale 1ns / 1ps

module kl_divergence_accumulator_tb;

    localparam int          PROB_W      = kld_pkg::PROB_W;
    localparam int          OUT_W       = kld_pkg::OUT_W;
    localparam int          S_DATA_W    = kld_pkg::S_DATA_W;
    localparam int          LOG_STEPS   = kld_pkg::LOG_STEPS;
    localparam logic [31:0] LN2_Q32     = kld_pkg::LN2_Q32;
    localparam int          FRAC        = kld_pkg::PROB_FRAC_BITS_DEF;
    localparam int          PAD_W       = S_DATA_W - 2 * PROB_W;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          HOLD_CYCLES = 400;
    localparam longint      SUM_HI      = 64'sd140737488355327;
    localparam longint      SUM_LO      = -64'sd140737488355328;
    localparam longint      OUT_HI      = 64'sd2147483647;
    localparam longint      OUT_LO      = -64'sd2147483648;

    typedef struct packed {
        logic [OUT_W-1:0] influence;
        logic             saturated;
    } kld_out_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // class_prob, global_prob, zero pad
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // influence
    logic                m_tuser;   // saturated

    kld_out_t pending_results[$];
    longint   div_sum;
    logic     div_overflow;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_left;
    int       err_count;
    int       slots_sent;
    int       results_seen;
    int       clipped_seen;
    int       cycle_count;

    kl_divergence_accumulator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // log2 in q.16: normalize, then truncating squaring steps
    function automatic int log2_q16(input logic [PROB_W-1:0] x);
        int              msb;
        int              frac;
        longint unsigned mant;
        msb  = 0;
        frac = 0;
        for (int b = 0; b < PROB_W; b++)
            if (x[b])
                msb = b;
        mant = longint'(x) << (30 - msb);
        repeat (LOG_STEPS)
        begin
            mant = (mant * mant) >> 30;
            frac = frac << 1;
            if (mant >= 64'h8000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        return (msb - FRAC) * 65536 + frac;
    endfunction

    task automatic predict_slot(input logic [PROB_W-1:0] p, input logic [PROB_W-1:0] q,
                                input logic last);
        int              d;
        longint unsigned mag;
        longint unsigned ln_mag;
        longint unsigned t_mag;
        longint          sum_next;
        longint          v;
        kld_out_t        res;
        if (p != 0 && q != 0)
        begin
            d        = log2_q16(p) - log2_q16(q);
            mag      = (d < 0) ? longint'(-d) : longint'(d);
            ln_mag   = (mag * {32'd0, LN2_Q32}) >> 32;
            t_mag    = (longint'(p) * ln_mag) >> FRAC;
            sum_next = div_sum + ((d < 0) ? -longint'(t_mag) : longint'(t_mag));
            if (sum_next > SUM_HI)
            begin
                sum_next     = SUM_HI;
                div_overflow = 1'b1;
            end
            else if (sum_next < SUM_LO)
            begin
                sum_next     = SUM_LO;
                div_overflow = 1'b1;
            end
            div_sum = sum_next;
        end
        if (last)
        begin
            v             = div_sum;
            res.saturated = div_overflow;
            if (v > OUT_HI)
            begin
                v             = OUT_HI;
                res.saturated = 1'b1;
            end
            else if (v < OUT_LO)
            begin
                v             = OUT_LO;
                res.saturated = 1'b1;
            end
            res.influence = v[OUT_W-1:0];
            pending_results.push_back(res);
            div_sum      = 0;
            div_overflow = 1'b0;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_slot(input logic [PROB_W-1:0] p, input logic [PROB_W-1:0] q,
                             input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {{PAD_W{1'b0}}, q, p};
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_slot(p, q, last);
        slots_sent++;
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [PROB_W-1:0] pick_prob();
        case ($urandom_range(9))
            0:       return '0;
            1:       return PROB_W'($urandom_range(1, 15));
            2:       return PROB_W'(65536);
            3:       return PROB_W'($urandom_range(65537, 131071));
            4:       return PROB_W'(131071);
            5:       return PROB_W'($urandom_range(1, 65536));
            default: return PROB_W'($urandom_range(0, 131071));
        endcase
    endfunction

    task automatic test_directed_slots();
        send_slot(17'd65536, 17'd65536, 1'b1);
        send_slot(17'd0, 17'd0, 1'b1);
        send_slot(17'd0, 17'd65536, 1'b1);
        send_slot(17'd65536, 17'd0, 1'b1);
        send_slot(17'd1, 17'd131071, 1'b1);
        send_slot(17'd131071, 17'd1, 1'b1);
        send_slot(17'd48218, 17'd131071, 1'b1);
        send_slot(17'd131071, 17'd131071, 1'b0);
        send_slot(17'd1, 17'd1, 1'b0);
        send_slot(17'd32768, 17'd65536, 1'b0);
        send_slot(17'd65536, 17'd32768, 1'b1);
        send_slot(17'd30000, 17'd0, 1'b0);
        send_slot(17'd0, 17'd30000, 1'b0);
        send_slot(17'd100, 17'd200, 1'b1);
        send_slot(17'd65537, 17'd65535, 1'b0);
        send_slot(17'd43690, 17'd21845, 1'b0);
        send_slot(17'd21845, 17'd43690, 1'b1);
        send_slot(17'h15555, 17'h0aaaa, 1'b0);
        send_slot(17'h0aaaa, 17'h15555, 1'b1);
        send_slot(17'd0, 17'd0, 1'b0);
        send_slot(17'd5, 17'd0, 1'b1);
        wait_results_drained();
    endtask

    // largest terms until the sum passes the 32-bit limit
    task automatic test_output_clip();
        while (div_sum <= OUT_HI)
            send_slot(17'd131071, 17'd1, 1'b0);
        repeat (3)
            send_slot(17'd131071, 17'd1, 1'b0);
        send_slot(17'd65536, 17'd0, 1'b1);
        wait_results_drained();
    endtask

    task automatic test_backpressure();
        hold_left = HOLD_CYCLES;
        repeat (8)
            send_slot(pick_prob(), pick_prob(), 1'b1);
        wait_results_drained();
    endtask

    task automatic test_random_attributes(input int n_slots, input int snd_pct,
                                          input int rcv_pct);
        int count;
        int len;
        count         = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (count < n_slots)
        begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(9) == 0)
                    send_slot(PROB_W'($urandom), PROB_W'($urandom), 1'b0);
                else
                    send_slot(pick_prob(), pick_prob(), i == len - 1);
                count++;
            end
        end
        send_slot(pick_prob(), pick_prob(), 1'b1);
        wait_results_drained();
    endtask

    // result side: ready pattern and long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end
            else
                m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic check_result();
        kld_out_t want;
        if (pending_results.size() == 0)
        begin
            err_count++;
            $display("%0t: unexpected result influence %h saturated %b",
                     $time, m_tdata, m_tuser);
        end
        else
        begin
            want = pending_results.pop_front();
            results_seen++;
            if (m_tuser)
                clipped_seen++;
            if (m_tdata !== want.influence)
            begin
                err_count++;
                $display("%0t: influence mismatch expected %h actual %h",
                         $time, want.influence, m_tdata);
            end
            if (m_tuser !== want.saturated)
            begin
                err_count++;
                $display("%0t: saturated mismatch expected %b actual %b",
                         $time, want.saturated, m_tuser);
            end
        end
    endtask

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            check_result();

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("kl_divergence_accumulator_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        div_sum       = 0;
        div_overflow  = 1'b0;
        send_idle_pct = 10;
        recv_idle_pct = 50;
        hold_left     = 0;
        err_count     = 0;
        slots_sent    = 0;
        results_seen  = 0;
        clipped_seen  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_slots();
        test_output_clip();
        test_backpressure();
        test_random_attributes(12, 10, 50);
        test_random_attributes(12, 50, 10);
        test_random_attributes(12, 0, 0);

        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("covered %0d slots and %0d attribute results, %0d of them clipped,",
                 slots_sent, results_seen, clipped_seen);
        $display("with zero and above-one probabilities, output hold-off and idle mixes");
        if (err_count == 0)
            $display("kl_divergence_accumulator_tb: clean");
        else
            $display("kl_divergence_accumulator_tb: errors");
        $finish;
    end

endmodule
